// ===== design/affine_sequence_hash_update_defines.svh =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_SEQUENCE_HASH_UPDATE_DEFINES_SVH
`define AFFINE_SEQUENCE_HASH_UPDATE_DEFINES_SVH

// Checks that a property holds at every rising edge outside reset.
`define ASHU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a consequent holds whenever its antecedent holds.
`define ASHU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/ashu_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: package
// Widths, mixer constants, command type and state encodings.
// ----------------------------------------------------------------------------
package ashu_pkg;

  // Lane and field geometry.
  localparam int unsigned LaneCount    = 8;
  localparam int unsigned DigestFields = 8;
  localparam int unsigned SymW         = 32;
  localparam int unsigned WordW        = 32;
  localparam int unsigned DigestW      = 2 * WordW;
  localparam int unsigned LaneW        = (LaneCount > 1) ? $clog2(LaneCount) : 1;

  // Mixer and per-lane seed constants.
  localparam logic [WordW-1:0] MixK1     = 32'h7feb352d;
  localparam logic [WordW-1:0] MixK2     = 32'h846ca68b;
  localparam logic [WordW-1:0] SeedStepM = 32'h9e3779b9;
  localparam logic [WordW-1:0] SeedStepD = 32'ha5a5a5a5;
  localparam int unsigned      MixShA    = 16;
  localparam int unsigned      MixShB    = 15;

  // Command queue geometry.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            restart;
    logic            emit;
  } cmd_t;

  // Steps of one lane update on the shared multiplier.
  typedef enum logic [2:0] {
    StepMixM1,
    StepMixM2,
    StepMixD1,
    StepMixD2,
    StepProd,
    StepOff
  } step_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BkIdle,
    BkRun,
    BkEmit
  } bk_state_e;

  // Xor of a word with itself shifted right.
  function automatic logic [WordW-1:0] xorshift(input logic [WordW-1:0] v,
                                                input int unsigned sh);
    xorshift = v ^ (v >> sh);
  endfunction

endpackage

// ===== design/ashu_in_if.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: input channel
// Valid/ready channel carrying one symbol with its first and last marks.
// ----------------------------------------------------------------------------
interface ashu_in_if;
  import ashu_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            first;
  logic            last;

  modport source (output valid, output symbol, output first, output last, input ready);
  modport sink   (input valid, input symbol, input first, input last, output ready);
endinterface

// ===== design/ashu_out_if.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: output channel
// Valid/ready channel carrying the eight lane digests.
// ----------------------------------------------------------------------------
interface ashu_out_if;
  import ashu_pkg::*;

  logic               valid;
  logic               ready;
  logic [DigestW-1:0] lane0_digest;
  logic [DigestW-1:0] lane1_digest;
  logic [DigestW-1:0] lane2_digest;
  logic [DigestW-1:0] lane3_digest;
  logic [DigestW-1:0] lane4_digest;
  logic [DigestW-1:0] lane5_digest;
  logic [DigestW-1:0] lane6_digest;
  logic [DigestW-1:0] lane7_digest;

  modport source (
    output valid, input ready,
    output lane0_digest, output lane1_digest, output lane2_digest, output lane3_digest,
    output lane4_digest, output lane5_digest, output lane6_digest, output lane7_digest
  );
  modport sink (
    input valid, output ready,
    input lane0_digest, input lane1_digest, input lane2_digest, input lane3_digest,
    input lane4_digest, input lane5_digest, input lane6_digest, input lane7_digest
  );
endinterface

// ===== design/ashu_queue.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: command queue
// Short FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module ashu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ashu_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output ashu_pkg::cmd_t head_o,
  input  logic          pop_i
);
  import ashu_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/ashu_front.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: front end
// Accepts input requests, classifies them into commands and feeds the queue.
// ----------------------------------------------------------------------------
module ashu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ashu_in_if.sink        in_i,
  output logic           push_o,
  output ashu_pkg::cmd_t push_cmd_o,
  input  logic           full_i
);
  import ashu_pkg::*;

  logic slot_valid_q, slot_valid_d;
  cmd_t slot_q;
  logic accept;

  // The slot takes a new request when empty or when it drains this cycle.
  assign in_i.ready = !slot_valid_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = slot_valid_q;
  assign push_cmd_o = slot_q;

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (accept) begin
      slot_valid_d = 1'b1;
    end else if (!full_i) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // Classify the request: restart the lanes and/or emit the digest.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q.symbol  <= in_i.symbol;
      slot_q.restart <= in_i.first;
      slot_q.emit    <= in_i.last;
    end
  end

endmodule

// ===== design/ashu_back.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: back end
// Walks the lanes on one shared multiplier and registers the digest result.
// ----------------------------------------------------------------------------
`include "affine_sequence_hash_update_defines.svh"

module ashu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ashu_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  ashu_out_if.source     out_o
);
  import ashu_pkg::*;

  bk_state_e        state_q, state_d;
  step_e            step_q, step_d;
  logic [LaneW-1:0] lane_q, lane_d;
  logic [WordW-1:0] seed_m_q, seed_m_d;
  logic [WordW-1:0] key_d_q, key_d_d;
  logic [WordW-1:0] acc_q, mult_q, off_q;
  logic [WordW-1:0] lane_p_q [LaneCount];
  logic [WordW-1:0] lane_o_q [LaneCount];
  logic [DigestW-1:0] dig_q [DigestFields];
  logic             out_valid_q, out_valid_d;

  logic             out_free, lane_done, item_done;
  logic             start, out_load;
  logic [WordW-1:0] mul_a, mul_b, mul_lo, mix_fin, p_old, o_old;

  assign out_free  = !out_valid_q || out_o.ready;
  assign lane_done = (state_q == BkRun) && (step_q == StepOff);
  assign item_done = lane_done && (lane_q == LaneW'(LaneCount - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: if (q_valid_i) state_d = BkRun;
      BkRun:  if (item_done) state_d = BkEmit;
      BkEmit: if (!q_cmd_i.emit || out_free) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    start    = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BkIdle: start = q_valid_i;
      BkEmit: begin
        q_pop_o  = !q_cmd_i.emit || out_free;
        out_load = q_cmd_i.emit && out_free;
      end
      default: ;
    endcase
  end

  // Step, lane and seed counters.
  always_comb begin
    step_d   = step_q;
    lane_d   = lane_q;
    seed_m_d = seed_m_q;
    key_d_d  = key_d_q;
    if (start) begin
      step_d   = StepMixM1;
      lane_d   = '0;
      seed_m_d = q_cmd_i.symbol;
      key_d_d  = '0;
    end else if (state_q == BkRun) begin
      case (step_q)
        StepMixM1: step_d = StepMixM2;
        StepMixM2: step_d = StepMixD1;
        StepMixD1: step_d = StepMixD2;
        StepMixD2: step_d = StepProd;
        StepProd:  step_d = StepOff;
        default: begin
          step_d   = StepMixM1;
          lane_d   = item_done ? lane_q : lane_q + 1'b1;
          seed_m_d = seed_m_q + SeedStepM;
          key_d_d  = key_d_q + SeedStepD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      step_q      <= StepMixM1;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_m_q <= seed_m_d;
    key_d_q  <= key_d_d;
  end

  // Old lane map, replaced by the identity map on a restart request.
  assign p_old   = q_cmd_i.restart ? WordW'(1) : lane_p_q[lane_q];
  assign o_old   = q_cmd_i.restart ? '0 : lane_o_q[lane_q];
  assign mix_fin = xorshift(acc_q, MixShA);

  // Operand selection for the shared 32x32 multiplier.
  always_comb begin
    mul_a = mult_q;
    mul_b = p_old;
    case (step_q)
      StepMixM1: begin
        mul_a = xorshift(seed_m_q, MixShA);
        mul_b = MixK1;
      end
      StepMixM2: begin
        mul_a = xorshift(acc_q, MixShB);
        mul_b = MixK2;
      end
      StepMixD1: begin
        mul_a = xorshift(q_cmd_i.symbol ^ key_d_q, MixShA);
        mul_b = MixK1;
      end
      StepMixD2: begin
        mul_a = xorshift(acc_q, MixShB);
        mul_b = MixK2;
      end
      StepProd: begin
        mul_a = mult_q;
        mul_b = p_old;
      end
      StepOff: begin
        mul_a = mult_q;
        mul_b = o_old;
      end
      default: ;
    endcase
  end

  assign mul_lo = WordW'(mul_a * mul_b);

  // Mixer intermediates: the odd multiplier and the lane offset.
  always_ff @(posedge clk_i) begin
    if (state_q == BkRun) begin
      acc_q <= mul_lo;
      if (step_q == StepMixD1) begin
        mult_q <= {mix_fin[WordW-2:0], 1'b1};
      end
      if (step_q == StepProd) begin
        off_q <= mix_fin;
      end
    end
  end

  // Lane maps: restart on a first request, then product and offset updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LaneCount; k++) begin
        lane_p_q[k] <= WordW'(1);
        lane_o_q[k] <= '0;
      end
    end else if (state_q == BkRun) begin
      if (step_q == StepProd) begin
        lane_p_q[lane_q] <= mul_lo;
      end
      if (step_q == StepOff) begin
        lane_o_q[lane_q] <= mul_lo + off_q;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  for (genvar g = 0; g < DigestFields; g++) begin : g_dig
    always_ff @(posedge clk_i) begin
      if (out_load) begin
        if (g < LaneCount) begin
          dig_q[g] <= {lane_p_q[g], lane_o_q[g]};
        end else begin
          dig_q[g] <= '0;
        end
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lane0_digest = dig_q[0];
  assign out_o.lane1_digest = dig_q[1];
  assign out_o.lane2_digest = dig_q[2];
  assign out_o.lane3_digest = dig_q[3];
  assign out_o.lane4_digest = dig_q[4];
  assign out_o.lane5_digest = dig_q[5];
  assign out_o.lane6_digest = dig_q[6];
  assign out_o.lane7_digest = dig_q[7];

  // The queue head must stay present while its lanes are being worked.
  `ASHU_ASSERT_IMPL(a_run_has_cmd, state_q != BkIdle, q_valid_i, "back end lost its command")
  // A new result appears only right after the finishing state.
  `ASHU_ASSERT_IMPL(a_rise_from_emit, $rose(out_valid_q), $past(state_q == BkEmit),
                    "result raised outside the finishing state")
  // The lane walk never runs past the last lane.
  `ASHU_ASSERT(a_lane_range, lane_q <= LaneW'(LaneCount - 1), "lane index out of range")
  // A queued command is retired only in the finishing state.
  `ASHU_ASSERT_IMPL(a_pop_when_done, q_pop_o, $past(item_done) || state_q == BkEmit,
                    "command retired before its lanes were done")

endmodule

// ===== design/affine_sequence_hash_update.sv =====
// ----------------------------------------------------------------------------
// Affine sequence hash update: top level
// Eight-lane affine-map hash modulo 2^32 over a stream of 32-bit symbols.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one symbol per request with first and last marks; a request
//   is taken at a rising edge with valid and ready high. A first request puts
//   every lane back to the identity map before its symbol is applied; a last
//   request produces one result on out_o holding all eight lane digests
//   (product in bits 63..32, offset in bits 31..0).
//   In the back end each request is issued, then every lane takes six passes
//   through the one shared 32x32 multiplier (two per mixer call, one for the
//   product, one for the offset), and a finishing state retires the request.
//   A front slot and a two-entry command queue keep taking requests while the
//   back end works, so up to two requests can wait behind the one in work.
//   Reset clears all lanes to the identity map and empties the queue.
//   A stalled receiver holds the result register; the back end keeps working
//   and waits only when another result is ready to be written.
// ----------------------------------------------------------------------------
module affine_sequence_hash_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  ashu_in_if.sink     in_i,
  ashu_out_if.source  out_o
);
  import ashu_pkg::*;

  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_push_cmd, q_head;

  // Request intake and classification.
  ashu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_o     (q_push),
    .push_cmd_o (q_push_cmd),
    .full_i     (q_full)
  );

  // Decoupling queue.
  ashu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  // Lane update engine and result register.
  ashu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
